// File: rtl/rgb_color_histogram_unit_assert.svh
// assertion macros for the color histogram unit
// no dependencies; included by rgb_color_histogram_unit, which checks its own logic
`ifndef RGB_COLOR_HISTOGRAM_UNIT_ASSERT_SVH
`define RGB_COLOR_HISTOGRAM_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RGBH_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rgbh same-cycle check failed");

// next-cycle implication, checked out of reset
`define RGBH_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rgbh next-cycle check failed");

`endif

// File: rtl/rgbh_pkg.sv
// shared types and constants for the color histogram unit
// no dependencies; used by rgbh_divider and rgb_color_histogram_unit
package rgbh_pkg;

    localparam int DEF_MAX_BIN_BITS = 9;
    localparam int DEF_COUNT_BITS   = 24;

    localparam int CH_BITS       = 8;               // bits per color channel
    localparam int CFG_BITS      = 4;               // bin_bits register width
    localparam int ACT_BITS      = 2;
    localparam int READ_IDX_BITS = 9;
    localparam int SCALE_BITS    = 8;               // result scale is 2^8
    localparam int QUOT_BITS     = SCALE_BITS + 1;  // 0..256

    localparam int S_TDATA_BITS = 40;
    localparam int M_TDATA_BITS = 24;

    typedef enum logic [ACT_BITS-1:0] {
        ACT_COUNT = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// File: rtl/rgbh_divider.sv
// iterative restoring divider, one quotient bit per cycle
// depends on rgbh_pkg; computes floor(dividend*2^SCALE_BITS/divisor) for dividend <= divisor
module rgbh_divider
    import rgbh_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [COUNT_BITS-1:0] dividend,
    input  logic [COUNT_BITS-1:0] divisor,
    output logic [QUOT_BITS-1:0]  quotient,
    output div_status_t           status
);

    localparam int STEP_BITS = $clog2(QUOT_BITS + 1);

    logic [COUNT_BITS:0]    rem_reg, rem_next;
    logic [COUNT_BITS-1:0]  dvs_reg;
    logic [QUOT_BITS-1:0]   quot_reg, quot_next;
    logic [STEP_BITS-1:0]   step_reg;
    logic                   done_reg;
    logic                   take;
    logic [COUNT_BITS:0]    diff;

    // one compare-subtract step, then double the partial remainder
    always_comb begin
        take      = (rem_reg >= {1'b0, dvs_reg});
        diff      = take ? (rem_reg - {1'b0, dvs_reg}) : rem_reg;
        rem_next  = {diff[COUNT_BITS-1:0], 1'b0};
        quot_next = {quot_reg[QUOT_BITS-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (step_reg == STEP_BITS'(1));
            if (start) begin
                step_reg <= STEP_BITS'(QUOT_BITS);
            end else if (step_reg != '0) begin
                step_reg <= step_reg - STEP_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= {1'b0, dividend};
            dvs_reg  <= divisor;
            quot_reg <= '0;
        end else if (step_reg != '0) begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign quotient    = quot_reg;
    assign status.busy = (step_reg != '0);
    assign status.done = done_reg;

endmodule

// File: rtl/rgb_color_histogram_unit.sv
// quantized rgb color histogram: bin store, sequencer, output register
// depends on rgbh_pkg, rgbh_divider and rgb_color_histogram_unit_assert.svh
//
// The unit works on one item at a time and holds s_tready low while busy.
// A count item passes through accept, store read and saturating write-back
// with largest-count update. A read item passes through the store read,
// the restoring divider that produces one quotient bit per cycle (9 bits),
// and the load of the output register, which waits while that register
// still holds an untaken result; the result then waits in that register
// while the next item may already be accepted. A clear item zeroes one
// store entry per cycle over the whole store; the same clearing pass runs
// after reset, so s_tready first rises once that pass is done. The bin_bits
// register may be written at any time on cfg_valid/cfg_ready and applies
// to the next count item.
module rgb_color_histogram_unit
    import rgbh_pkg::*;
#(
    parameter int MAX_BIN_BITS = DEF_MAX_BIN_BITS,
    parameter int COUNT_BITS   = DEF_COUNT_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // configuration: bin_bits
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_BITS-1:0]     cfg_data,
    // input items
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_TDATA_BITS-1:0] s_tdata,   // red[7:0], green[15:8], blue[23:16], read_index[32:24]
    input  logic [ACT_BITS-1:0]     s_tuser,   // action[1:0]
    // result items
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_BITS-1:0] m_tdata    // bin_value[8:0], bin_echo[17:9]
);

`include "rgb_color_histogram_unit_assert.svh"

    localparam int ADDR_BITS = MAX_BIN_BITS;
    localparam int DEPTH     = 1 << MAX_BIN_BITS;
    localparam int IDX_BITS  = 3 * CH_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [7:0] {
        ST_CLR      = 8'b0000_0001,  // clearing pass over the store
        ST_IDLE     = 8'b0000_0010,
        ST_CNT_RD   = 8'b0000_0100,
        ST_CNT_WR   = 8'b0000_1000,
        ST_RD_RD    = 8'b0001_0000,
        ST_RD_START = 8'b0010_0000,
        ST_RD_WAIT  = 8'b0100_0000,
        ST_RD_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration register
    logic [CFG_BITS-1:0] bin_bits_reg;

    // input field unpacking
    logic [CH_BITS-1:0]       red, green, blue;
    logic [READ_IDX_BITS-1:0] read_index;
    assign red        = s_tdata[7:0];
    assign green      = s_tdata[15:8];
    assign blue       = s_tdata[23:16];
    assign read_index = s_tdata[32:24];

    // bin store
    logic [COUNT_BITS-1:0] bins_mem [DEPTH];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [ADDR_BITS-1:0]  addr_reg;
    logic [ADDR_BITS-1:0]  clr_addr_reg;
    logic                  mem_we;
    logic [ADDR_BITS-1:0]  mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;

    logic [COUNT_BITS-1:0]    largest_count_reg;
    logic [READ_IDX_BITS-1:0] echo_reg;

    // output register
    logic                     out_valid_reg;
    logic [QUOT_BITS-1:0]     out_value_reg;
    logic [READ_IDX_BITS-1:0] out_echo_reg;

    // divider
    logic                 div_start;
    logic [QUOT_BITS-1:0] div_quot;
    div_status_t          div_st;

    logic s_accept;
    logic out_load;
    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // effective bin bits, clamped to 1..MAX_BIN_BITS
    logic [4:0] n_eff;
    logic [8:0] n_mul;
    logic [3:0] bk, gk, rk;
    logic [1:0] n_rem;
    logic [CH_BITS-1:0]  r_top, g_top, b_top;
    logic [IDX_BITS-1:0] idx_w;
    logic [ADDR_BITS-1:0] pix_addr;

    always_comb begin
        n_eff = (bin_bits_reg == '0) ? 5'd1 : {1'b0, bin_bits_reg};
        if (int'(n_eff) > MAX_BIN_BITS) begin
            n_eff = 5'(MAX_BIN_BITS);
        end
        // n/3 by reciprocal, exact for n below 32
        n_mul = {4'b0, n_eff} * 9'd11;
        bk    = n_mul[8:5];
        n_rem = 2'(n_eff - 5'({1'b0, bk} * 5'd3));
        gk    = bk + ((n_rem != 2'd0) ? 4'd1 : 4'd0);
        rk    = bk + ((n_rem == 2'd2) ? 4'd1 : 4'd0);
        r_top = red   >> (4'(CH_BITS) - rk);
        g_top = green >> (4'(CH_BITS) - gk);
        b_top = blue  >> (4'(CH_BITS) - bk);
        // index is {red top bits, green top bits, blue top bits}
        idx_w = (IDX_BITS'(r_top) << (5'(gk) + 5'(bk)))
              | (IDX_BITS'(g_top) << bk)
              | IDX_BITS'(b_top);
        pix_addr = ADDR_BITS'(idx_w);
    end

    // saturating increment of the bin just read
    logic [COUNT_BITS-1:0] cnt_inc;
    assign cnt_inc = (rd_data_reg == COUNT_MAX) ? rd_data_reg : rd_data_reg + COUNT_BITS'(1);

    // store write port: clearing pass or count write-back
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = cnt_inc;
        if (state_reg == ST_CLR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end else if (state_reg == ST_CNT_WR) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            bins_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= bins_mem[addr_reg];
    end

    // sequencer
    assign out_load  = (state_reg == ST_RD_OUT) && (!out_valid_reg || m_tready);
    assign div_start = (state_reg == ST_RD_START);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLR: begin
                if (&clr_addr_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    case (action_t'(s_tuser))
                        ACT_COUNT: state_next = ST_CNT_RD;
                        ACT_READ:  state_next = ST_RD_RD;
                        ACT_CLEAR: state_next = ST_CLR;
                        default:   state_next = ST_IDLE;  // unused action, ignored
                    endcase
                end
            end
            ST_CNT_RD:   state_next = ST_CNT_WR;
            ST_CNT_WR:   state_next = ST_IDLE;
            ST_RD_RD:    state_next = ST_RD_START;
            ST_RD_START: state_next = ST_RD_WAIT;
            ST_RD_WAIT: begin
                if (div_st.done) begin
                    state_next = ST_RD_OUT;
                end
            end
            ST_RD_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_CLR;
            clr_addr_reg      <= '0;
            largest_count_reg <= '0;
            bin_bits_reg      <= CFG_BITS'(9);
            out_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                bin_bits_reg <= cfg_data;
            end
            if (state_reg == ST_CLR) begin
                clr_addr_reg <= clr_addr_reg + ADDR_BITS'(1);
            end
            if (s_accept && action_t'(s_tuser) == ACT_CLEAR) begin
                clr_addr_reg      <= '0;
                largest_count_reg <= '0;
            end
            // track the running maximum on count write-back
            if (state_reg == ST_CNT_WR && cnt_inc > largest_count_reg) begin
                largest_count_reg <= cnt_inc;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item payload capture
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            addr_reg <= (action_t'(s_tuser) == ACT_READ) ? ADDR_BITS'(read_index) : pix_addr;
            echo_reg <= read_index;
        end
        if (out_load) begin
            // empty histogram reads as zero
            out_value_reg <= (largest_count_reg == '0) ? '0 : div_quot;
            out_echo_reg  <= echo_reg;
        end
    end

    rgbh_divider #(
        .COUNT_BITS(COUNT_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (rd_data_reg),
        .divisor  (largest_count_reg),
        .quotient (div_quot),
        .status   (div_st)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_echo_reg, out_value_reg};

    // largest count never falls below a count just written back
    `RGBH_ASSERT_NEXT(a_largest_covers, aclk, aresetn, state_reg == ST_CNT_WR, largest_count_reg >= $past(cnt_inc))
    // the divider only finishes while the sequencer waits for it
    `RGBH_ASSERT_NOW(a_div_done_wait, aclk, aresetn, div_st.done, state_reg == ST_RD_WAIT)
    // a new division never starts on top of a running one
    `RGBH_ASSERT_NOW(a_div_start_free, aclk, aresetn, div_start, !div_st.busy)

endmodule

// File: tb/tb.sv
// self-checking bench for rgb_color_histogram_unit: pixel counting, normalized bin reads, clears
// depends on rgbh_pkg and the unit's rtl; a small tracker class predicts every read result
module tb
    import rgbh_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BIN_BITS  = DEF_MAX_BIN_BITS;
    localparam int COUNT_BITS    = DEF_COUNT_BITS;
    localparam int STORE_DEPTH   = 1 << MAX_BIN_BITS;
    localparam int SCALE_LIMIT   = 1 << SCALE_BITS;
    localparam int COLOR_BITS    = 3 * CH_BITS;
    // a clear (or the pass after reset) keeps the unit busy while it zeroes every store entry
    localparam int SETTLE_CYCLES = STORE_DEPTH + 88;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int GAP_PERCENT   = 13;
    localparam int PHASE_ITEMS   = 250;

    // the one action code the package leaves unnamed; the unit ignores it
    localparam logic [ACT_BITS-1:0] ACT_SPARE = 2'd3;

    typedef struct {
        logic [ACT_BITS-1:0]      action;
        logic [CH_BITS-1:0]       red;
        logic [CH_BITS-1:0]       green;
        logic [CH_BITS-1:0]       blue;
        logic [READ_IDX_BITS-1:0] read_index;
    } pixel_item_t;

    typedef struct {
        logic [QUOT_BITS-1:0]     bin_value;
        logic [READ_IDX_BITS-1:0] bin_echo;
    } bin_reading_t;

    // keeps its own copy of the bin store and predicts every normalized reading
    class histogram_tracker;
        logic [COUNT_BITS-1:0] bin_counts [STORE_DEPTH];
        logic [COUNT_BITS-1:0] largest;
        logic [CFG_BITS-1:0]   bin_bits;
        bin_reading_t          readings_due [$];
        int unsigned           mismatches;
        int unsigned           readings_checked;

        function new();
            foreach (bin_counts[i]) bin_counts[i] = '0;
            largest          = '0;
            bin_bits         = CFG_BITS'(MAX_BIN_BITS);
            mismatches       = 0;
            readings_checked = 0;
        endfunction

        function int unsigned effective_bits();
            int unsigned n;
            n = bin_bits;
            if (n < 1) n = 1;
            if (n > MAX_BIN_BITS) n = MAX_BIN_BITS;
            return n;
        endfunction

        // blue keeps n/3 top bits, green one more for n%3 >= 1, red one more for n%3 == 2
        function int unsigned bin_of(logic [CH_BITS-1:0] r, logic [CH_BITS-1:0] g,
                                     logic [CH_BITS-1:0] b);
            int unsigned n, bk, gk, rk, idx;
            n   = effective_bits();
            bk  = n / 3;
            gk  = bk + (((n % 3) >= 1) ? 1 : 0);
            rk  = bk + (((n % 3) == 2) ? 1 : 0);
            idx = ((int'(r) >> (CH_BITS - rk)) << (gk + bk))
                | ((int'(g) >> (CH_BITS - gk)) << bk)
                |  (int'(b) >> (CH_BITS - bk));
            return idx % STORE_DEPTH;
        endfunction

        function void note_item(pixel_item_t it);
            int unsigned       idx;
            longint unsigned   scaled;
            bin_reading_t      rd;
            case (it.action)
                ACT_COUNT: begin
                    idx = bin_of(it.red, it.green, it.blue);
                    if (bin_counts[idx] != {COUNT_BITS{1'b1}})
                        bin_counts[idx] = bin_counts[idx] + 1'b1;
                    if (bin_counts[idx] > largest)
                        largest = bin_counts[idx];
                end
                ACT_READ: begin
                    scaled = 0;
                    if (largest != 0) begin
                        scaled = (longint'(bin_counts[it.read_index]) << SCALE_BITS) / largest;
                        if (scaled > SCALE_LIMIT) scaled = SCALE_LIMIT;
                    end
                    rd.bin_value = scaled[QUOT_BITS-1:0];
                    rd.bin_echo  = it.read_index;
                    readings_due.push_back(rd);
                end
                ACT_CLEAR: begin
                    foreach (bin_counts[i]) bin_counts[i] = '0;
                    largest = '0;
                end
                default: ;
            endcase
        endfunction

        function void check_reading(logic [M_TDATA_BITS-1:0] word);
            bin_reading_t got, want;
            got.bin_value = word[QUOT_BITS-1:0];
            got.bin_echo  = word[QUOT_BITS +: READ_IDX_BITS];
            if (readings_due.size() == 0) begin
                $error("unexpected result item, m_tdata %h", word);
                mismatches++;
                return;
            end
            want = readings_due.pop_front();
            readings_checked++;
            if (got.bin_value !== want.bin_value) begin
                $error("bin_value: expected %0d, actual %0d", want.bin_value, got.bin_value);
                mismatches++;
            end
            if (got.bin_echo !== want.bin_echo) begin
                $error("bin_echo: expected %0d, actual %0d", want.bin_echo, got.bin_echo);
                mismatches++;
            end
        endfunction
    endclass

    // clock, reset and every input start at known values
    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_BITS-1:0]     cfg_data  = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata   = '0;   // red, green, blue, read_index, zero fill
    logic [ACT_BITS-1:0]     s_tuser   = '0;   // action
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;          // bin_value, bin_echo, zero fill

    histogram_tracker tracker = new();

    // both sides skip the gaps while this is set
    bit no_gaps = 1'b0;

    // a few colors per phase so that bins fill up unevenly
    logic [COLOR_BITS-1:0] palette [8];

    int unsigned action_tally [4];
    int unsigned settings_used;

    rgb_color_histogram_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 10 ns period
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // hard stop well beyond the slowest correct run
    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    function automatic bit take_gap();
        return !no_gaps && ($urandom_range(0, 99) < GAP_PERCENT);
    endfunction

    // result side: ready changes on the falling edge, results are taken on the rising edge
    always @(negedge aclk) begin
        m_tready <= !take_gap();
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_reading(m_tdata);
    end

    function automatic pixel_item_t make_item(logic [ACT_BITS-1:0] action,
                                              logic [CH_BITS-1:0] r, logic [CH_BITS-1:0] g,
                                              logic [CH_BITS-1:0] b,
                                              logic [READ_IDX_BITS-1:0] idx);
        pixel_item_t it;
        it.action     = action;
        it.red        = r;
        it.green      = g;
        it.blue       = b;
        it.read_index = idx;
        return it;
    endfunction

    // called on a falling edge, returns on the falling edge after the item is taken
    task automatic push_item(input pixel_item_t it);
        // random gaps before the item, valid low meanwhile
        while (take_gap()) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.action;
        s_tdata  <= S_TDATA_BITS'({it.read_index, it.blue, it.green, it.red});
        do @(posedge aclk); while (!s_tready);
        tracker.note_item(it);
        action_tally[it.action]++;
        @(negedge aclk);
    endtask

    // register writes only happen with the unit idle
    task automatic write_bin_bits(input logic [CFG_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        tracker.bin_bits = value;
        settings_used++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // wait for every pending reading, then give a clear time to finish
    task automatic settle_idle();
        int unsigned waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (tracker.readings_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // mostly palette pixels and reads of bins those pixels land in, plus noise
    function automatic pixel_item_t random_item();
        pixel_item_t           it;
        int unsigned           roll, pick;
        logic [COLOR_BITS-1:0] color;
        it = make_item(ACT_COUNT, CH_BITS'($urandom_range(0, 255)),
                       CH_BITS'($urandom_range(0, 255)), CH_BITS'($urandom_range(0, 255)),
                       READ_IDX_BITS'($urandom_range(0, STORE_DEPTH - 1)));
        roll = $urandom_range(0, 99);
        if (roll < 68) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                color = palette[0];
            end else if (pick < 8) begin
                color = palette[$urandom_range(1, 7)];
            end else begin
                color = {it.blue, it.green, it.red};
            end
            {it.blue, it.green, it.red} = color;
        end else if (roll < 94) begin
            it.action = ACT_READ;
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                color = palette[$urandom_range(0, 7)];
                it.read_index = READ_IDX_BITS'(tracker.bin_of(color[7:0], color[15:8],
                                                              color[23:16]));
            end else if (pick < 8) begin
                // within the bins in use
                it.read_index = READ_IDX_BITS'(
                    $urandom_range(0, (1 << tracker.effective_bits()) - 1));
            end
            // otherwise anywhere in the store, beyond the bins in use too
        end else if (roll < 95) begin
            it.action = ACT_CLEAR;
        end else begin
            it.action = ACT_SPARE;
        end
        return it;
    endfunction

    task automatic run_phase(input logic [CFG_BITS-1:0] setting);
        int unsigned counted;
        pixel_item_t it;
        settle_idle();
        write_bin_bits(setting);
        foreach (palette[i]) palette[i] = COLOR_BITS'($urandom());
        // sometimes start from an empty histogram, sometimes keep old counts
        if ($urandom_range(0, 1) != 0)
            push_item(make_item(ACT_CLEAR, 8'h00, 8'h00, 8'h00, '0));
        counted = 0;
        while (counted < PHASE_ITEMS) begin
            it = random_item();
            push_item(it);
            if (it.action != ACT_SPARE) counted++;
        end
    endtask

    // extremes first, then the usual range; values beyond the store clamp to the top
    logic [CFG_BITS-1:0] phase_settings [8] = '{4'd1, 4'd0, 4'd15, 4'd9, 4'd4, 4'd2, 4'd8, 4'd5};

    initial begin
        int unsigned a, b;
        foreach (action_tally[i]) action_tally[i] = 0;
        settings_used = 0;

        // reset held from time zero, released on a falling edge
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part at the reset setting of 9 bin bits
        // reads of an empty histogram return zero
        push_item(make_item(ACT_READ, 8'h00, 8'h00, 8'h00, 9'd0));
        push_item(make_item(ACT_READ, 8'hff, 8'hff, 8'hff, 9'd511));
        // darkest and brightest pixels land in the first and last bin
        push_item(make_item(ACT_COUNT, 8'h00, 8'h00, 8'h00, 9'd0));
        push_item(make_item(ACT_COUNT, 8'hff, 8'hff, 8'hff, 9'd511));
        push_item(make_item(ACT_COUNT, 8'hff, 8'hff, 8'hff, 9'h1ff));
        // largest bin reads full scale, half-filled bin reads half, empty reads zero
        push_item(make_item(ACT_READ, 8'h00, 8'h00, 8'h00, 9'd511));
        push_item(make_item(ACT_READ, 8'hff, 8'hff, 8'hff, 9'd0));
        push_item(make_item(ACT_READ, 8'h5a, 8'ha5, 8'h3c, 9'd300));
        // unused action code changes nothing
        push_item(make_item(ACT_SPARE, 8'hff, 8'hff, 8'hff, 9'd511));
        push_item(make_item(ACT_COUNT, 8'h80, 8'h40, 8'h20, 9'd0));
        push_item(make_item(ACT_COUNT, 8'h1f, 8'he0, 8'h7f, 9'd0));
        a = tracker.bin_of(8'h80, 8'h40, 8'h20);
        b = tracker.bin_of(8'h1f, 8'he0, 8'h7f);
        push_item(make_item(ACT_READ, 8'h00, 8'h00, 8'h00, READ_IDX_BITS'(a)));
        push_item(make_item(ACT_READ, 8'h00, 8'h00, 8'h00, READ_IDX_BITS'(b)));
        push_item(make_item(ACT_READ, 8'h00, 8'h00, 8'h00, 9'd0));
        // clear empties every bin and the largest count
        push_item(make_item(ACT_CLEAR, 8'h12, 8'h34, 8'h56, 9'd170));
        push_item(make_item(ACT_READ, 8'h00, 8'h00, 8'h00, 9'd511));
        push_item(make_item(ACT_COUNT, 8'haa, 8'h55, 8'haa, 9'd85));
        a = tracker.bin_of(8'haa, 8'h55, 8'haa);
        push_item(make_item(ACT_READ, 8'h00, 8'h00, 8'h00, READ_IDX_BITS'(a)));
        push_item(make_item(ACT_SPARE, 8'h00, 8'h00, 8'h00, 9'd0));
        push_item(make_item(ACT_READ, 8'h00, 8'h00, 8'h00, 9'd256));

        // random phases, one per bin_bits setting; one phase runs with no gaps at all
        foreach (phase_settings[i]) begin
            no_gaps = (i == 3);
            run_phase(phase_settings[i]);
        end
        no_gaps = 1'b0;

        // wait for the last readings and any clear still running
        settle_idle();
        if (tracker.readings_due.size() != 0) begin
            $error("%0d readings never arrived", tracker.readings_due.size());
            tracker.mismatches += tracker.readings_due.size();
        end

        $display("tb: %0d counts, %0d reads, %0d clears, %0d unused-code items, %0d bin_bits writes",
                 action_tally[ACT_COUNT], action_tally[ACT_READ], action_tally[ACT_CLEAR],
                 action_tally[ACT_SPARE], settings_used);
        $display("tb: %0d normalized readings checked, %0d mismatches",
                 tracker.readings_checked, tracker.mismatches);
        if (tracker.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/rgbh_pkg.sv
rtl/rgbh_divider.sv
rtl/rgb_color_histogram_unit.sv
tb/tb.sv
